FILE: src/rpa_pkg.sv
// Shared types and codes for the reference-counted page allocator.
package rpa_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ADDREF = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Status codes of a result item
  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NO_MEM  = 3'd1,
    STAT_RANGE   = 3'd2,
    STAT_UNALLOC = 3'd3,
    STAT_SAT     = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_t;

  // Control states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  localparam int PAGE_W    = 10;
  localparam int STATUS_W  = 3;
  localparam int REFCNT_W  = 8;
  localparam int CFG_W     = 11;
  localparam int FIRST_W   = 10;

endpackage

FILE: src/rpa_req_if.sv
// Request channel: valid/ready handshake carrying one allocator operation.
interface rpa_req_if;
  import rpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [PAGE_W-1:0]   page;

  modport source (output valid, output operation, output page, input ready);
  modport sink   (input valid, input operation, input page, output ready);
endinterface

FILE: src/rpa_rsp_if.sv
// Response channel: valid/ready handshake carrying one allocator result.
interface rpa_rsp_if;
  import rpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [PAGE_W-1:0]   granted_page;
  logic [STATUS_W-1:0] status;
  logic [REFCNT_W-1:0] ref_count;
  logic                released;

  modport source (output valid, output granted_page, output status, output ref_count,
                  output released, input ready);
  modport sink   (input valid, input granted_page, input status, input ref_count,
                  input released, output ready);
endinterface

FILE: src/rpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/refcounted_page_allocator.sv
// Page allocator top level: free-page stack, fresh-page counter and per-page reference counts.
//
//   channel   dir  handshake        payload
//   in_req    in   valid/ready      operation, page
//   out_rsp   out  valid/ready      granted_page, status, ref_count, released
//   cfg_*     in   cfg_we only      cfg_index, cfg_data (first_page, page_limit)
//
// Per item: on the accept edge the count RAM and the stack RAM are read; in the next
// cycle the count RAM and stack RAM are written as the operation needs and the result
// is loaded into the output register. One item is in flight at a time.
// After reset a clearing pass zeroes the count RAM, one entry a cycle, over all NUM_PAGES
// entries; no item is accepted during it.
// A waiting result does not block the next accept when it is taken in the same cycle.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES   = 1024,
  parameter int COUNT_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  rpa_req_if.sink           in_req,
  rpa_rsp_if.source         out_rsp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int CW = (DW > CFG_W) ? DW : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Control and configuration state
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r;
  logic [FIRST_W-1:0]   first_page_r;
  logic [CFG_W-1:0]     page_limit_r;
  logic [DW-1:0]        stack_depth_r, stack_depth_nxt;
  logic [DW-1:0]        fresh_taken_r, fresh_taken_nxt;
  op_t                  op_r;
  logic [PAGE_W-1:0]    page_r;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]    granted_r, granted_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [REFCNT_W-1:0]  refcnt_r, refcnt_nxt;
  logic                 released_r, released_nxt;

  // Memory ports
  logic                   cnt_we, exec_cnt_we;
  logic [AW-1:0]          cnt_waddr, exec_cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, exec_cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic                   stk_we;
  logic [AW-1:0]          stk_waddr;
  logic [AW-1:0]          stk_wdata;
  logic [AW-1:0]          stk_raddr;
  logic [AW-1:0]          stk_rdata;

  // Datapath helpers
  logic                 in_acc, out_acc;
  logic [CW-1:0]        lim, first_w, fresh_w, page_w, fresh_pg;
  logic                 in_range, fresh_ok;
  logic [AW-1:0]        idx;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  assign in_acc  = in_req.valid && in_req.ready;
  assign out_acc = out_valid_r && out_rsp.ready;

  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.granted_page = granted_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.ref_count    = refcnt_r;
  assign out_rsp.released     = released_r;

  // Reference count store
  rpa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (AW'(in_req.page)),
    .rdata (cnt_rdata)
  );

  // Returned-page stack store
  rpa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign stk_raddr = AW'(stack_depth_r - DW'(1));

  // Clearing pass owns the count RAM write port until it ends
  always_comb begin
    if (state_r == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = exec_cnt_we;
      cnt_waddr = exec_cnt_waddr;
      cnt_wdata = exec_cnt_wdata;
    end
  end

  // Range and fresh-page arithmetic
  always_comb begin
    lim      = (CW'(page_limit_r) > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(page_limit_r);
    first_w  = CW'(first_page_r);
    fresh_w  = CW'(fresh_taken_r);
    page_w   = CW'(page_r);
    in_range = (page_w >= first_w) && (page_w < lim);
    fresh_ok = (lim > first_w) && ((lim - first_w) > fresh_w);
    fresh_pg = lim - CW'(1) - fresh_w;
    idx      = AW'(page_r);
    cnt_dec  = cnt_rdata - COUNT_WIDTH'(1);
  end

  // Execute one item: read data is back, write the stores as needed and form the result
  always_comb begin
    exec_cnt_we     = 1'b0;
    exec_cnt_waddr  = idx;
    exec_cnt_wdata  = '0;
    stk_we          = 1'b0;
    stk_waddr       = AW'(stack_depth_r);
    stk_wdata       = idx;
    stack_depth_nxt = stack_depth_r;
    fresh_taken_nxt = fresh_taken_r;
    granted_nxt     = '0;
    status_nxt      = STAT_OK;
    refcnt_nxt      = '0;
    released_nxt    = 1'b0;

    if (state_r == S_EXEC) begin
      case (op_r)
        OP_ALLOC: begin
          if (stack_depth_r != '0) begin
            // pop the most recently returned page
            stack_depth_nxt = stack_depth_r - DW'(1);
            exec_cnt_we     = 1'b1;
            exec_cnt_waddr  = stk_rdata;
            exec_cnt_wdata  = COUNT_WIDTH'(1);
            granted_nxt     = PAGE_W'(stk_rdata);
            refcnt_nxt      = REFCNT_W'(1);
          end else if (fresh_ok) begin
            // hand out the highest never-used page
            fresh_taken_nxt = fresh_taken_r + DW'(1);
            exec_cnt_we     = 1'b1;
            exec_cnt_waddr  = AW'(fresh_pg);
            exec_cnt_wdata  = COUNT_WIDTH'(1);
            granted_nxt     = PAGE_W'(fresh_pg);
            refcnt_nxt      = REFCNT_W'(1);
          end else begin
            status_nxt = STAT_NO_MEM;
          end
        end
        OP_FREE: begin
          if (!in_range) begin
            status_nxt = STAT_RANGE;
          end else if (cnt_rdata == '0) begin
            status_nxt = STAT_UNALLOC;
          end else begin
            exec_cnt_we    = 1'b1;
            exec_cnt_wdata = cnt_dec;
            if (cnt_dec == '0 && stack_depth_r < DW'(NUM_PAGES)) begin
              // last reference gone and stack not full: push the page
              stk_we          = 1'b1;
              stack_depth_nxt = stack_depth_r + DW'(1);
              released_nxt    = 1'b1;
            end else begin
              refcnt_nxt = REFCNT_W'(cnt_dec);
            end
          end
        end
        OP_ADDREF: begin
          if (!in_range) begin
            status_nxt = STAT_RANGE;
          end else if (cnt_rdata == '0) begin
            status_nxt = STAT_UNALLOC;
          end else if (cnt_rdata == COUNT_MAX) begin
            status_nxt = STAT_SAT;
            refcnt_nxt = REFCNT_W'(COUNT_MAX);
          end else begin
            exec_cnt_we    = 1'b1;
            exec_cnt_wdata = cnt_rdata + COUNT_WIDTH'(1);
            refcnt_nxt     = REFCNT_W'(cnt_rdata + COUNT_WIDTH'(1));
          end
        end
        default: begin
          // unknown operation: answer all zero, change nothing
        end
      endcase
    end
  end

  // Next control state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == AW'(NUM_PAGES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Output register valid: load on execute, drop when taken
  always_comb begin
    if (state_r == S_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      first_page_r  <= '0;
      page_limit_r  <= CFG_W'(1024);
      stack_depth_r <= '0;
      fresh_taken_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_depth_r <= stack_depth_nxt;
      fresh_taken_r <= fresh_taken_nxt;
      out_valid_r   <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_PAGE: first_page_r <= cfg_data[FIRST_W-1:0];
          CFG_PAGE_LIMIT: page_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: hold the accepted item and the pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_t'(in_req.operation);
      page_r <= in_req.page;
    end
    if (state_r == S_EXEC) begin
      granted_r  <= granted_nxt;
      status_r   <= status_nxt;
      refcnt_r   <= refcnt_nxt;
      released_r <= released_nxt;
    end
  end

  // No item is taken before the clearing pass ends
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == S_IDLE))
    else $error("item accepted outside idle state");

  // Execute never overwrites a result still waiting
  a_out_free_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result register busy at execute");

  // Stack never grows beyond its store
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_depth_r <= DW'(NUM_PAGES))
    else $error("stack depth beyond store size");

  // Fresh pages handed out never exceed the managed pages
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_taken_r <= DW'(NUM_PAGES))
    else $error("fresh page count beyond store size");

  // A push always goes with a good status and a zero count
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && released_r) |-> (status_r == STAT_OK && refcnt_r == '0))
    else $error("released with bad status or count");

endmodule
